FILE: hdl/mmxc_pkg.sv
`timescale 1ns / 1ps
// Shared types for the matrix multiply checksum unit: control word,
// status group, sequencer conditions and the microcode table.
// No dependencies.
package mmxc_pkg;

  typedef logic [2:0] step_t;

  // Microcode step addresses
  localparam step_t ST_LOAD  = 3'd0;
  localparam step_t ST_CLEAR = 3'd1;
  localparam step_t ST_MAC   = 3'd2;
  localparam step_t ST_DRAIN = 3'd3;
  localparam step_t ST_EMIT  = 3'd4;

  typedef enum logic [2:0] {
    CND_ALWAYS,
    CND_IN_LAST,
    CND_MAC_LAST,
    CND_PIPE_EMPTY,
    CND_OUT_FREE
  } cond_t;

  typedef struct packed {
    logic  in_rdy;    // take input items, write the stores
    logic  clr;       // clear loop counters and checksum
    logic  issue;     // issue one multiply-accumulate
    logic  load_out;  // move checksum to the output register
    cond_t cond;
    step_t tgt;       // next step when cond holds
    step_t alt;       // next step otherwise
  } ctl_t;

  typedef struct packed {
    logic in_last;
    logic mac_last;
    logic pipe_empty;
    logic out_free;
  } stat_t;

  function automatic ctl_t ucode(step_t s);
    ctl_t w;
    w = '{in_rdy: 1'b0, clr: 1'b0, issue: 1'b0, load_out: 1'b0,
          cond: CND_ALWAYS, tgt: ST_LOAD, alt: ST_LOAD};
    case (s)
      ST_LOAD: begin
        w.in_rdy = 1'b1;
        w.cond   = CND_IN_LAST;
        w.tgt    = ST_CLEAR;
        w.alt    = ST_LOAD;
      end
      ST_CLEAR: begin
        w.clr  = 1'b1;
        w.cond = CND_ALWAYS;
        w.tgt  = ST_MAC;
        w.alt  = ST_MAC;
      end
      ST_MAC: begin
        w.issue = 1'b1;
        w.cond  = CND_MAC_LAST;
        w.tgt   = ST_DRAIN;
        w.alt   = ST_MAC;
      end
      ST_DRAIN: begin
        w.cond = CND_PIPE_EMPTY;
        w.tgt  = ST_EMIT;
        w.alt  = ST_DRAIN;
      end
      ST_EMIT: begin
        w.load_out = 1'b1;
        w.cond     = CND_OUT_FREE;
        w.tgt      = ST_LOAD;
        w.alt      = ST_EMIT;
      end
      default: begin
        w.cond = CND_ALWAYS;
        w.tgt  = ST_LOAD;
        w.alt  = ST_LOAD;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: hdl/matrix_multiply_xor_checksum_unit.sv
`timescale 1ns / 1ps
// Loads one element item per cycle; an item with tlast starts C = A * B.
// One multiply-accumulate per cycle: after the last item is taken, DIM^3 MACs
// run, then out_tvalid rises and in_tready returns in that same cycle. An
// untaken earlier checksum holds the emit; the single MAC unit and its store
// read ports pace the computation.
// Synchronous active-low reset returns to the load step, output empty;
// element stores are not cleared and hold nothing defined until written.
module matrix_multiply_xor_checksum_unit #(
  parameter int DIM = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // row_index[3:0], col_index[7:4], a_value[39:8], b_value[71:40]
  input  logic [71:0] in_tdata,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // checksum[31:0]
  output logic [31:0] out_tdata
);

  mmxc_pkg::ctl_t  ctl;
  mmxc_pkg::stat_t stat;

  logic        in_acc;
  logic        mac_last;
  logic        pipe_empty;
  logic [31:0] checksum;

  logic        out_valid_r;
  logic [31:0] out_data_r;

  assign in_tready = ctl.in_rdy;
  assign in_acc    = in_tvalid && in_tready;

  assign stat.in_last    = in_acc && in_tlast;
  assign stat.mac_last   = mac_last;
  assign stat.pipe_empty = pipe_empty;
  assign stat.out_free   = !out_valid_r || out_tready;

  mmxc_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl)
  );

  mmxc_dp #(
    .DIM (DIM)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .wr_en      (in_acc),
    .row_index  (in_tdata[3:0]),
    .col_index  (in_tdata[7:4]),
    .a_value    (in_tdata[39:8]),
    .b_value    (in_tdata[71:40]),
    .mac_last   (mac_last),
    .pipe_empty (pipe_empty),
    .checksum   (checksum)
  );

  // Output register: hold the checksum until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.load_out && stat.out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out && stat.out_free) begin
      out_data_r <= checksum;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_stop_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> !in_tready)
    else $error("input still ready after last item");

  a_idle_when_loading: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> pipe_empty)
    else $error("MAC pipeline busy while loading");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.load_out && stat.out_free) |=> out_tvalid)
    else $error("checksum not presented after emit");

endmodule

FILE: hdl/mmxc_seq.sv
`timescale 1ns / 1ps
// Microcode sequencer: step counter, control word lookup, conditional jumps.
// Depends on mmxc_pkg.
module mmxc_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  mmxc_pkg::stat_t  stat,
  output mmxc_pkg::ctl_t   ctl
);

  mmxc_pkg::step_t step_r;
  mmxc_pkg::step_t step_nxt;
  logic            hit;

  assign ctl = mmxc_pkg::ucode(step_r);

  always_comb begin
    case (ctl.cond)
      mmxc_pkg::CND_ALWAYS:     hit = 1'b1;
      mmxc_pkg::CND_IN_LAST:    hit = stat.in_last;
      mmxc_pkg::CND_MAC_LAST:   hit = stat.mac_last;
      mmxc_pkg::CND_PIPE_EMPTY: hit = stat.pipe_empty;
      mmxc_pkg::CND_OUT_FREE:   hit = stat.out_free;
      default:                  hit = 1'b0;
    endcase
    step_nxt = hit ? ctl.tgt : ctl.alt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= mmxc_pkg::ST_LOAD;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

FILE: hdl/mmxc_dp.sv
`timescale 1ns / 1ps
// Datapath: A and B element stores, loop counters, one pipelined
// multiply-accumulate unit, rotating row accumulators and the checksum.
// Depends on mmxc_pkg.
module mmxc_dp #(
  parameter int DIM = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  mmxc_pkg::ctl_t  ctl,
  input  logic            wr_en,
  input  logic [3:0]      row_index,
  input  logic [3:0]      col_index,
  input  logic [31:0]     a_value,
  input  logic [31:0]     b_value,
  output logic            mac_last,
  output logic            pipe_empty,
  output logic [31:0]     checksum
);

  localparam int AW    = $clog2(DIM);
  localparam int XW    = AW + 4;
  localparam int DEPTH = 1 << (2 * AW);

  logic [31:0] mem_a [DEPTH];
  logic [31:0] mem_b [DEPTH];

  logic [XW-1:0] row_x;
  logic [XW-1:0] col_x;
  logic          in_range;

  logic [AW-1:0] r_r, k_r, c_r;
  logic          r_end, k_end, c_end;

  logic [31:0] rd_a_r, rd_b_r;
  logic        v1_r, first1_r, lastk1_r;
  logic [31:0] prod_r;
  logic        v2_r, first2_r, lastk2_r;

  logic [31:0] ring_r [DIM];
  logic [31:0] acc_sum;
  logic [31:0] chk_r;

  assign row_x    = XW'(row_index);
  assign col_x    = XW'(col_index);
  assign in_range = (row_x < XW'(DIM)) && (col_x < XW'(DIM));

  assign r_end = (r_r == AW'(DIM - 1));
  assign k_end = (k_r == AW'(DIM - 1));
  assign c_end = (c_r == AW'(DIM - 1));

  assign mac_last   = r_end && k_end && c_end;
  assign pipe_empty = !v1_r && !v2_r;
  assign checksum   = chk_r;

  // Element stores: one write port, one registered read port each
  always_ff @(posedge clk) begin
    if (wr_en && in_range) begin
      mem_a[{row_x[AW-1:0], col_x[AW-1:0]}] <= a_value;
      mem_b[{row_x[AW-1:0], col_x[AW-1:0]}] <= b_value;
    end
    rd_a_r <= mem_a[{r_r, k_r}];
    rd_b_r <= mem_b[{k_r, c_r}];
  end

  // Loop counters in i-k-j order, c innermost
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_r <= '0;
      k_r <= '0;
      c_r <= '0;
    end else if (ctl.clr) begin
      r_r <= '0;
      k_r <= '0;
      c_r <= '0;
    end else if (ctl.issue) begin
      c_r <= c_end ? '0 : c_r + AW'(1);
      if (c_end) begin
        k_r <= k_end ? '0 : k_r + AW'(1);
        if (k_end) begin
          r_r <= r_end ? '0 : r_r + AW'(1);
        end
      end
    end
  end

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= ctl.issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    first1_r <= (k_r == '0);
    lastk1_r <= k_end;
    first2_r <= first1_r;
    lastk2_r <= lastk1_r;
    prod_r   <= 32'(rd_a_r * rd_b_r);
  end

  // Start the row from zero on the first k pass instead of clearing it
  assign acc_sum = (first2_r ? 32'd0 : ring_r[0]) + prod_r;

  // Rotate the accumulators: head is consumed, new sum enters at the tail
  always_ff @(posedge clk) begin
    if (v2_r) begin
      for (int i = 0; i < DIM - 1; i++) begin
        ring_r[i] <= ring_r[i + 1];
      end
      ring_r[DIM - 1] <= acc_sum;
    end
  end

  // Fold each finished row element into the checksum on the last k pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_r <= '0;
    end else if (ctl.clr) begin
      chk_r <= '0;
    end else if (v2_r && lastk2_r) begin
      chk_r <= chk_r ^ acc_sum;
    end
  end

endmodule
